### design/rrgi_pkg.sv
// Shared codes and widths for the round-robin group interleaver.
// Used by the top level and by its checker; depends on nothing.
package rrgi_pkg;

    // Command codes on the opcode port
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // Port field widths
    localparam int GV_W  = 12;
    localparam int POS_W = 12;

    // Occupancy bitmap word: 32 groups per word
    localparam int OCC_W  = 32;
    localparam int OCC_BW = 5;

    typedef logic [OCC_W-1:0] occ_word_t;

endpackage

### design/round_robin_group_interleave.sv
// Round-robin group interleaver: per-group position queues in linked memories,
// occupancy bitmap words with per-word flags, and a small sequencer.
// Depends on rrgi_pkg.
//
// A rejected load or an emit on an empty store is answered from idle; a load
// passes S_LD_WR; an emit passes S_EM_SEL, S_EM_HT and S_EM_POP when the next
// group sits in the scan word, with S_EM_SEL1 after S_EM_SEL otherwise. An emit
// that leaves its group non-empty stays busy through its done cycle to write the
// new head in S_EM_LNK. No new item is taken while busy. Memory reads are
// registered; the word search is one priority encode over the occupancy flags.
// Reset clears the counters, scan pointer and occupancy flags at once; the
// memories are not cleared and no sweep is needed. The receiver cannot stall.
module round_robin_group_interleave
    import rrgi_pkg::*;
#(
    parameter int MAX_ITEMS  = 4096,
    parameter int MAX_GROUPS = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             opcode,
    input  logic [GV_W-1:0]  group_value,
    output logic             done,
    output logic [POS_W-1:0] position,
    output logic             valid_res,
    output logic             last,
    output logic             error
);

    localparam int PW    = $clog2(MAX_ITEMS);
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int GW    = $clog2(MAX_GROUPS);
    localparam int WORDS = (MAX_GROUPS + OCC_W - 1) / OCC_W;
    localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GXW   = WIW + OCC_BW;

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LD_WR   = 3'd1;
    localparam logic [2:0] S_EM_SEL  = 3'd2;
    localparam logic [2:0] S_EM_SEL1 = 3'd3;
    localparam logic [2:0] S_EM_HT   = 3'd4;
    localparam logic [2:0] S_EM_POP  = 3'd5;
    localparam logic [2:0] S_EM_LNK  = 3'd6;

    // Memories
    occ_word_t     occ_mem  [WORDS];
    logic [PW-1:0] head_mem [MAX_GROUPS];
    logic [PW-1:0] tail_mem [MAX_GROUPS];
    logic [PW-1:0] link_mem [MAX_ITEMS];

    // Registered read data
    occ_word_t     occ_rd_reg;
    logic [PW-1:0] head_rd_reg;
    logic [PW-1:0] tail_rd_reg;
    logic [PW-1:0] link_rd_reg;

    // Control and result registers
    logic [2:0]       state_reg;
    logic [GW-1:0]    g_reg;
    logic [WIW-1:0]   w_reg;
    occ_word_t        word_reg;
    logic [CW-1:0]    loaded_reg;
    logic [CW-1:0]    emitted_reg;
    logic [GW-1:0]    scan_reg;
    logic [WORDS-1:0] nz_reg;
    logic             done_reg;
    logic [POS_W-1:0] position_reg;
    logic             valid_reg;
    logic             last_reg;
    logic             error_reg;

    // Memory port controls
    logic           occ_we;
    logic [WIW-1:0] occ_wa;
    occ_word_t      occ_wd;
    logic [WIW-1:0] occ_ra;
    logic [GW-1:0]  grp_ra;
    logic           head_we;
    logic [PW-1:0]  head_wd;
    logic           tail_we;
    logic           link_we;

    // Decoded fields
    logic [GV_W-1:0] gm1;
    logic [GW-1:0]   g_in;
    logic [GXW-1:0]  gin_ext;
    logic [GXW-1:0]  g_ext;
    logic [GXW-1:0]  scan_ext;
    logic [WIW-1:0]  w_g;
    logic [OCC_BW-1:0] b_g;
    logic [WIW-1:0]  w_scan;
    logic [OCC_BW-1:0] b_scan;
    logic            load_err;
    logic            store_empty;
    occ_word_t       ld_word;
    logic            ld_hit;
    logic [PW-1:0]   ld_pos;
    occ_word_t       sel_word;
    occ_word_t       sel_masked;
    logic            fnd_hi;
    logic [WIW-1:0]  w_hi;
    logic [WIW-1:0]  w_lo;
    logic [WIW-1:0]  w_pick;
    occ_word_t       pop_word;
    logic            pop_end;
    logic [CW-1:0]   emitted_next;
    logic [GW-1:0]   scan_next;

    // Lowest set bit of an occupancy word
    function automatic logic [OCC_BW-1:0] low_bit(input occ_word_t v);
        logic [OCC_BW-1:0] r;
        r = '0;
        for (int i = OCC_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = OCC_BW'(i);
            end
        end
        return r;
    endfunction

    // Split group numbers into word and bit
    assign gm1         = group_value - GV_W'(1);
    assign g_in        = GW'(gm1);
    assign gin_ext     = GXW'(g_in);
    assign g_ext       = GXW'(g_reg);
    assign scan_ext    = GXW'(scan_reg);
    assign w_g         = g_ext[GXW-1:OCC_BW];
    assign b_g         = g_ext[OCC_BW-1:0];
    assign w_scan      = scan_ext[GXW-1:OCC_BW];
    assign b_scan      = scan_ext[OCC_BW-1:0];

    assign load_err    = (group_value == '0) || (32'(group_value) > MAX_GROUPS)
                         || (32'(loaded_reg) >= MAX_ITEMS);
    assign store_empty = (emitted_reg >= loaded_reg);

    // Load: current occupancy of the target group
    assign ld_word = nz_reg[w_g] ? occ_rd_reg : '0;
    assign ld_hit  = ld_word[b_g];
    assign ld_pos  = loaded_reg[PW-1:0];

    // Emit: groups at or above the scan pointer in the scan word
    assign sel_word   = nz_reg[w_scan] ? occ_rd_reg : '0;
    assign sel_masked = sel_word & ({OCC_W{1'b1}} << b_scan);

    // Find the next non-empty word after the scan word, else wrap to the first
    always_comb
    begin
        fnd_hi = 1'b0;
        w_hi   = '0;
        w_lo   = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (nz_reg[i])
            begin
                w_lo = WIW'(i);
                if (i > int'(w_scan))
                begin
                    fnd_hi = 1'b1;
                    w_hi   = WIW'(i);
                end
            end
        end
        w_pick = fnd_hi ? w_hi : w_lo;
    end

    // Pop bookkeeping
    assign pop_word     = word_reg & ~(occ_word_t'(1) << b_g);
    assign pop_end      = (head_rd_reg == tail_rd_reg);
    assign emitted_next = emitted_reg + CW'(1);
    assign scan_next    = (g_reg == GW'(MAX_GROUPS - 1)) ? '0 : g_reg + GW'(1);

    // Memory port steering
    always_comb
    begin
        occ_we  = 1'b0;
        occ_wa  = w_g;
        occ_wd  = ld_word | (occ_word_t'(1) << b_g);
        occ_ra  = '0;
        grp_ra  = g_reg;
        head_we = 1'b0;
        head_wd = ld_pos;
        tail_we = 1'b0;
        link_we = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                occ_ra = (opcode == OP_EMIT) ? w_scan : gin_ext[GXW-1:OCC_BW];
                grp_ra = g_in;
            end
            S_LD_WR:
            begin
                tail_we = 1'b1;
                if (ld_hit)
                begin
                    link_we = 1'b1;
                end
                else
                begin
                    head_we = 1'b1;
                    occ_we  = 1'b1;
                end
            end
            S_EM_SEL:
            begin
                occ_ra = w_pick;
            end
            S_EM_POP:
            begin
                if (pop_end)
                begin
                    occ_we = 1'b1;
                    occ_wd = pop_word;
                end
            end
            S_EM_LNK:
            begin
                head_we = 1'b1;
                head_wd = link_rd_reg;
            end
            S_EM_SEL1, S_EM_HT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_wa] <= occ_wd;
        end
        if (head_we)
        begin
            head_mem[g_reg] <= head_wd;
        end
        if (tail_we)
        begin
            tail_mem[g_reg] <= ld_pos;
        end
        if (link_we)
        begin
            link_mem[tail_rd_reg] <= ld_pos;
        end
        occ_rd_reg  <= occ_mem[occ_ra];
        head_rd_reg <= head_mem[grp_ra];
        tail_rd_reg <= tail_mem[grp_ra];
        link_rd_reg <= link_mem[head_rd_reg];
    end

    // Sequencer, counters and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            g_reg        <= '0;
            w_reg        <= '0;
            word_reg     <= '0;
            loaded_reg   <= '0;
            emitted_reg  <= '0;
            scan_reg     <= '0;
            nz_reg       <= '0;
            done_reg     <= 1'b0;
            position_reg <= '0;
            valid_reg    <= 1'b0;
            last_reg     <= 1'b0;
            error_reg    <= 1'b0;
        end
        else
        begin
            // drop the result after its one cycle
            done_reg     <= 1'b0;
            position_reg <= '0;
            valid_reg    <= 1'b0;
            last_reg     <= 1'b0;
            error_reg    <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (opcode == OP_LOAD)
                        begin
                            g_reg <= g_in;
                            if (load_err)
                            begin
                                done_reg  <= 1'b1;
                                error_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_LD_WR;
                            end
                        end
                        else if (store_empty)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_EM_SEL;
                        end
                    end
                end
                S_LD_WR:
                begin
                    // append position to its group
                    if (!ld_hit)
                    begin
                        nz_reg[w_g] <= 1'b1;
                    end
                    loaded_reg <= loaded_reg + CW'(1);
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                S_EM_SEL:
                begin
                    if (sel_masked != '0)
                    begin
                        g_reg     <= GW'({w_scan, low_bit(sel_masked)});
                        word_reg  <= sel_word;
                        state_reg <= S_EM_HT;
                    end
                    else
                    begin
                        w_reg     <= w_pick;
                        state_reg <= S_EM_SEL1;
                    end
                end
                S_EM_SEL1:
                begin
                    g_reg     <= GW'({w_reg, low_bit(occ_rd_reg)});
                    word_reg  <= occ_rd_reg;
                    state_reg <= S_EM_HT;
                end
                S_EM_HT:
                begin
                    state_reg <= S_EM_POP;
                end
                S_EM_POP:
                begin
                    // pop the oldest position and advance the scan
                    done_reg     <= 1'b1;
                    valid_reg    <= 1'b1;
                    position_reg <= POS_W'(head_rd_reg);
                    if (pop_end)
                    begin
                        nz_reg[w_g] <= (pop_word != '0);
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_EM_LNK;
                    end
                    if (emitted_next >= loaded_reg)
                    begin
                        last_reg    <= 1'b1;
                        loaded_reg  <= '0;
                        emitted_reg <= '0;
                        scan_reg    <= '0;
                    end
                    else
                    begin
                        emitted_reg <= emitted_next;
                        scan_reg    <= scan_next;
                    end
                end
                S_EM_LNK:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign position  = position_reg;
    assign valid_res = valid_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

### design/rrgi_checker.sv
// Port-level checks for the round-robin group interleaver, bound to the top.
// Depends on rrgi_pkg.
module rrgi_checker
    import rrgi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             opcode,
    input logic [GV_W-1:0]  group_value,
    input logic             done,
    input logic [POS_W-1:0] position,
    input logic             valid_res,
    input logic             last,
    input logic             error
);

    // A result never carries both a position and an error
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(valid_res && error))
        else $error("valid result flagged as error");

    // Only an emitted position can end the set
    assert property (@(posedge clk) disable iff (!rst_n)
        last |-> (valid_res && !error))
        else $error("last without an emitted position");

    // Result fields stay quiet outside the strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (position == '0 && !valid_res && !last && !error))
        else $error("result fields active without done");

    // A load never returns a position in either cycle where its result can appear
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_LOAD) |=> !valid_res ##1 !valid_res)
        else $error("load produced a valid position");

endmodule

bind round_robin_group_interleave rrgi_checker u_rrgi_checker (.*);

### bench/tb_round_robin_group_interleave.sv
// Self-checking bench for the round-robin group interleaver: queued load and emit items,
// a clocked driver and monitor, and an in-bench predictor of the group queues.
// Depends on rrgi_pkg and round_robin_group_interleave.
module tb_round_robin_group_interleave
    import rrgi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS   = 4096;
    localparam int N_GROUPS  = 256;
    localparam int RAND_GOAL = 1850;

    typedef struct packed {
        logic            op;
        logic [GV_W-1:0] gv;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             vld;
        logic             lst;
        logic             err;
    } answer_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             opcode = OP_LOAD;
    logic [GV_W-1:0]  group_value = '0;
    logic             busy;
    logic             done;
    logic [POS_W-1:0] position;
    logic             valid_res;
    logic             last;
    logic             error;

    // Pending items and answers still owed by the block
    cmd_t    pending_cmds[$];
    answer_t expected_answers[$];

    // Predicted state of the group queues
    logic [POS_W-1:0] link_mem [N_ITEMS];
    logic [POS_W-1:0] grp_head [N_GROUPS];
    logic [POS_W-1:0] grp_tail [N_GROUPS];
    logic             grp_live [N_GROUPS];
    logic [12:0]      n_loaded;
    logic [12:0]      n_emitted;
    logic [7:0]       scan_ptr;

    // Shadow counts that let the stimulus close each set
    int gen_loaded;
    int gen_emitted;

    int fails;
    int n_accepted;
    int n_positions;
    int n_sets;
    int n_rejects;

    round_robin_group_interleave #(
        .MAX_ITEMS  (N_ITEMS),
        .MAX_GROUPS (N_GROUPS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .group_value (group_value),
        .done        (done),
        .position    (position),
        .valid_res   (valid_res),
        .last        (last),
        .error       (error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clear all groups and counters for a new set
    task automatic clear_groups();
        for (int i = 0; i < N_GROUPS; i++)
        begin
            grp_live[i] = 1'b0;
        end
        n_loaded  = '0;
        n_emitted = '0;
        scan_ptr  = '0;
    endtask

    // Work out the answer to one accepted item and advance the queues
    task automatic interleave_predict(input logic op, input logic [GV_W-1:0] gv,
                                      output answer_t ans);
        logic [7:0]       g;
        logic [POS_W-1:0] p;
        logic             found;
        ans = '0;
        found = 1'b0;
        if (op == OP_LOAD)
        begin
            if (gv == 0 || gv > N_GROUPS || n_loaded >= N_ITEMS)
            begin
                ans.err = 1'b1;
            end
            else
            begin
                g = 8'(gv - 1);
                p = n_loaded[POS_W-1:0];
                if (grp_live[g])
                begin
                    link_mem[grp_tail[g]] = p;
                end
                else
                begin
                    grp_head[g] = p;
                    grp_live[g] = 1'b1;
                end
                grp_tail[g] = p;
                n_loaded = n_loaded + 1'b1;
            end
        end
        else if (n_emitted < n_loaded)
        begin
            // Scan upward from the pointer, wrapping, and pop the first live group
            for (int k = 0; k < N_GROUPS; k++)
            begin
                g = scan_ptr + 8'(k);
                if (!found && grp_live[g])
                begin
                    found = 1'b1;
                    p = grp_head[g];
                    if (p == grp_tail[g])
                        grp_live[g] = 1'b0;
                    else
                        grp_head[g] = link_mem[p];
                    scan_ptr  = g + 8'd1;
                    n_emitted = n_emitted + 1'b1;
                    ans.pos = p;
                    ans.vld = 1'b1;
                    if (n_emitted >= n_loaded)
                    begin
                        ans.lst = 1'b1;
                        clear_groups();
                    end
                end
            end
        end
    endtask

    // Queue one item and track how full the store will be
    task automatic queue_cmd(input logic op, input int gv);
        cmd_t c;
        c.op = op;
        c.gv = gv[GV_W-1:0];
        pending_cmds = {pending_cmds, c};
        if (op == OP_LOAD)
        begin
            if (gv >= 1 && gv <= N_GROUPS && gen_loaded < N_ITEMS)
            begin
                gen_loaded++;
            end
        end
        else if (gen_emitted < gen_loaded)
        begin
            gen_emitted++;
            if (gen_emitted == gen_loaded)
            begin
                gen_loaded  = 0;
                gen_emitted = 0;
            end
        end
    endtask

    // Emit until the current set is closed
    task automatic drain_set();
        while (gen_loaded != 0)
        begin
            queue_cmd(OP_EMIT, $urandom_range(0, 4095));
        end
    endtask

    function automatic int bad_group();
        return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(N_GROUPS + 1, 4095));
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // Present queued items; hold each until accepted, idle at random outside a quiet stretch
    always @(posedge clk or negedge rst_n)
    begin : drive
        answer_t ans;
        cmd_t    nxt;
        if (!rst_n)
        begin
            start       <= 1'b0;
            opcode      <= OP_LOAD;
            group_value <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                interleave_predict(opcode, group_value, ans);
                expected_answers = {expected_answers, ans};
                n_accepted++;
            end
            if (!start || !busy)
            begin
                if (pending_cmds.size() != 0 &&
                    !((n_accepted < 300 || n_accepted >= 900) && $urandom_range(0, 99) < 18))
                begin
                    nxt = pending_cmds.pop_front();
                    start       <= 1'b1;
                    opcode      <= nxt.op;
                    group_value <= nxt.gv;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Check every strobed answer against the oldest prediction
    always @(posedge clk)
    begin : observe
        answer_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected answer, expected none, actual position %0d valid %0d",
                         $time, position, valid_res);
                fails++;
            end
            else
            begin
                want = expected_answers.pop_front();
                check_field("position", want.pos, position);
                check_field("valid_res", want.vld, valid_res);
                check_field("last", want.lst, last);
                check_field("error", want.err, error);
                n_positions += want.vld;
                n_sets      += want.lst;
                n_rejects   += want.err;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : stimulus
        int pool [8];
        int npool;
        int nset;
        int room;
        clear_groups();

        // Directed: empty emit, rejected groups, wrap of the scan, load during emission
        queue_cmd(OP_EMIT, 0);
        queue_cmd(OP_LOAD, 0);
        queue_cmd(OP_LOAD, N_GROUPS + 1);
        queue_cmd(OP_LOAD, 4095);
        queue_cmd(OP_LOAD, 2048);
        queue_cmd(OP_LOAD, 1);
        queue_cmd(OP_LOAD, N_GROUPS);
        queue_cmd(OP_LOAD, 1);
        queue_cmd(OP_LOAD, 128);
        queue_cmd(OP_LOAD, N_GROUPS);
        queue_cmd(OP_LOAD, 3);
        queue_cmd(OP_EMIT, 4095);
        queue_cmd(OP_EMIT, 0);
        queue_cmd(OP_LOAD, 2);
        repeat (5) queue_cmd(OP_EMIT, 0);
        queue_cmd(OP_EMIT, 0);

        // Random sets over a few groups, with stray emits, bad loads and noise
        while (pending_cmds.size() < RAND_GOAL)
        begin
            room = RAND_GOAL - pending_cmds.size();
            if ($urandom_range(0, 99) < 85)
            begin
                nset  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
                // cap the set at half of the remaining item budget
                if (nset > room / 2)
                    nset = (room / 2 > 0) ? room / 2 : 1;
                npool = $urandom_range(1, 8);
                for (int k = 0; k < npool; k++)
                begin
                    pool[k] = ($urandom_range(0, 3) == 0) ? N_GROUPS - $urandom_range(0, 3)
                                                          : $urandom_range(1, N_GROUPS);
                end
                for (int k = 0; k < nset; k++)
                begin
                    if (gen_loaded != 0 && $urandom_range(0, 9) == 0)
                        queue_cmd(OP_EMIT, $urandom_range(0, 4095));
                    if ($urandom_range(0, 19) == 0)
                        queue_cmd(OP_LOAD, bad_group());
                    queue_cmd(OP_LOAD, pool[$urandom_range(0, npool - 1)]);
                end
                drain_set();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    queue_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 4095));
            end
        end
        drain_set();

        // Release reset and let the driver run the queue dry
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_cmds.size() != 0 || start || expected_answers.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (expected_answers.size() != 0)
        begin
            $display("%0t: %0d answers never arrived", $time, expected_answers.size());
            fails++;
        end
        $display("Ran %0d items: %0d positions emitted over %0d closed sets, %0d loads rejected.",
                 n_accepted, n_positions, n_sets, n_rejects);
        $display("Covered bad groups, empty emits, scan wrap and loads during emission.");
        if (fails == 0)
            $display("[round_robin_group_interleave] OK");
        else
            $display("[round_robin_group_interleave] ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #3_000_000;
        $display("Timeout with %0d items pending", pending_cmds.size());
        $display("[round_robin_group_interleave] ERROR");
        $finish;
    end

endmodule

### sim.f
design/rrgi_pkg.sv
design/round_robin_group_interleave.sv
design/rrgi_checker.sv
bench/tb_round_robin_group_interleave.sv
